>>> hw/rtl/ftr_pkg.sv
// ----------------------------------------------------------------------------
// ftr_pkg: shared definitions for the frame interval rate throttle
// Field widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package ftr_pkg;

	// Fixed field widths
	localparam int INTV_W = 24;
	localparam int TS_W   = 48;
	localparam int RATE_W = 32;
	localparam int WS_W   = 7;
	localparam int CFG_W  = 24;
	localparam int IDXC_W = 2;

	// Configuration register indexes
	localparam logic [IDXC_W-1:0] REG_WINDOW_SIZE  = 2'd0;
	localparam logic [IDXC_W-1:0] REG_MAX_STDEV    = 2'd1;
	localparam logic [IDXC_W-1:0] REG_MAX_INTERVAL = 2'd2;
	localparam logic [IDXC_W-1:0] REG_TARGET_PER   = 2'd3;

	// Register values after reset
	localparam logic [WS_W-1:0]   RST_WINDOW_SIZE  = 7'd10;
	localparam logic [CFG_W-1:0]  RST_MAX_STDEV    = 24'd20000;
	localparam logic [CFG_W-1:0]  RST_MAX_INTERVAL = 24'd40000;
	localparam logic [CFG_W-1:0]  RST_TARGET_PER   = 24'd33333;

	localparam logic [INTV_W-1:0] INTV_MAX = '1;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_RD,
		S_POP,
		S_PUSH,
		S_M1,
		S_M2,
		S_M3,
		S_DMEAN,
		S_WMEAN,
		S_DVAR,
		S_WVAR,
		S_DECIDE,
		S_M5,
		S_M6,
		S_DRATE,
		S_WRATE,
		S_OUT
	} seq_state_t;

endpackage

>>> hw/rtl/ftr_ram.sv
// ----------------------------------------------------------------------------
// ftr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ftr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/ftr_div.sv
// ----------------------------------------------------------------------------
// ftr_div: shared restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module ftr_div #(
	parameter int W = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	// Trial subtraction of the divisor from the shifted remainder.
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/frame_interval_rate_throttle.sv
// ----------------------------------------------------------------------------
// frame_interval_rate_throttle: frame interval statistics and rate slowdown
// Keeps a window of frame intervals, tests mean and spread, requests a rate.
// ----------------------------------------------------------------------------
// Usage:
// One frame event is a transfer on the input channel (in_valid/in_ready).
// Each event yields exactly one result transfer on the output channel
// (out_valid/out_ready). Configuration is written through cfg_wr_en,
// cfg_index and cfg_wdata while the block is idle; writing the window size
// empties the window.
// Sequencing: an inactive-sensor or no-subscriber event raises out_valid in the
// cycle after its input transfer. A full event runs a short sequence of
// multiply steps and two divisions on the shared bit-serial divider before
// out_valid rises. A throttled event adds two multiply steps and a third
// division. One event is processed at a time; in_ready is high only when
// the block is idle, so the next event is taken only after the previous
// result has been taken by the receiver.
// The result is held in output registers until out_ready takes it; a stall
// simply delays the return to idle.
// Reset empties the window, clears the last timestamp and restores the
// default register values; the interval ring needs no clearing.
// ----------------------------------------------------------------------------
module frame_interval_rate_throttle #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration port
	input  logic                         cfg_wr_en,
	input  logic [ftr_pkg::IDXC_W-1:0]   cfg_index,
	input  logic [ftr_pkg::CFG_W-1:0]    cfg_wdata,
	// Input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ftr_pkg::TS_W-1:0]     timestamp_us,
	input  logic                         sensor_active,
	input  logic                         subscribers_present,
	input  logic [ftr_pkg::RATE_W-1:0]   current_rate,
	// Output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         published,
	output logic                         throttle,
	output logic [ftr_pkg::RATE_W-1:0]   next_rate,
	output logic [ftr_pkg::INTV_W-1:0]   mean_interval_us,
	output logic [ftr_pkg::TS_W-1:0]     interval_variance,
	output logic                         adequate
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int SUM_W = ftr_pkg::INTV_W + CNT_W;
	localparam int SQ_W  = 2 * ftr_pkg::INTV_W + CNT_W;
	localparam int SPR_W = SQ_W + CNT_W;
	localparam int NUM_W = ftr_pkg::RATE_W + ftr_pkg::INTV_W + CNT_W;
	localparam int DIV_W = (SPR_W > NUM_W) ? SPR_W : NUM_W;
	localparam int SQV_W = 2 * ftr_pkg::INTV_W;
	localparam int RT_W  = ftr_pkg::RATE_W + ftr_pkg::INTV_W;

	ftr_pkg::seq_state_t state_q, state_d;

	// Configuration registers
	logic [ftr_pkg::WS_W-1:0]   ws_q;
	logic [ftr_pkg::CFG_W-1:0]  max_stdev_q;
	logic [ftr_pkg::CFG_W-1:0]  max_intv_q;
	logic [ftr_pkg::CFG_W-1:0]  target_q;

	// Window state
	logic [IDX_W-1:0]           head_q;
	logic [CNT_W-1:0]           count_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic [ftr_pkg::TS_W-1:0]   last_q;

	// Per-event working registers
	logic [ftr_pkg::RATE_W-1:0] rate_q;
	logic [ftr_pkg::INTV_W-1:0] v_q;
	logic [SQV_W-1:0]           vsq_q;
	logic [ftr_pkg::INTV_W-1:0] old_q;
	logic [SQV_W-1:0]           oldsq_q;
	logic                       full_q;
	logic [SPR_W-1:0]           p1_q;
	logic [SPR_W-1:0]           p2_q;
	logic [SPR_W-1:0]           spread_q;
	logic [2*CNT_W-1:0]         n2_q;
	logic [SQV_W-1:0]           lim2_q;
	logic [SPR_W-1:0]           limn_q;
	logic [SUM_W-1:0]           mint_q;
	logic [NUM_W-1:0]           num_q;

	// Result registers
	logic                         pub_q;
	logic                         thr_q;
	logic [ftr_pkg::RATE_W-1:0]   next_q;
	logic [ftr_pkg::INTV_W-1:0]   mean_q;
	logic [ftr_pkg::TS_W-1:0]     var_q;
	logic                         adq_q;

	// Combinational helpers
	logic                         in_xfer;
	logic [CNT_W-1:0]             w_eff;
	logic [ftr_pkg::TS_W-1:0]     diff;
	logic                         backward;
	logic [ftr_pkg::INTV_W-1:0]   delta;
	logic [IDX_W+1:0]             slot_sum;
	logic [IDX_W-1:0]             slot;
	logic                         adq_now;
	logic                         thr_now;

	// RAM and divider controls
	logic                         ram_we;
	logic                         ram_re;
	logic [ftr_pkg::INTV_W-1:0]   ram_rdata;
	logic                         div_start;
	logic [DIV_W-1:0]             div_dividend;
	logic [DIV_W-1:0]             div_divisor;
	logic                         div_done;
	logic [DIV_W-1:0]             div_quo;

	assign in_xfer = in_valid && in_ready;

	// Effective window length: zero acts as one, large values clamp.
	always_comb begin
		if (ws_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (int'(ws_q) > WINDOW_MAX) begin
			w_eff = CNT_W'(WINDOW_MAX);
		end else begin
			w_eff = CNT_W'(ws_q);
		end
	end

	// New interval, saturated; a backward timestamp gives zero.
	assign diff     = timestamp_us - last_q;
	assign backward = timestamp_us < last_q;
	always_comb begin
		if (backward) begin
			delta = '0;
		end else if (|diff[ftr_pkg::TS_W-1:ftr_pkg::INTV_W]) begin
			delta = ftr_pkg::INTV_MAX;
		end else begin
			delta = diff[ftr_pkg::INTV_W-1:0];
		end
	end

	// Write slot behind the newest entry, modulo the ring depth.
	always_comb begin
		slot_sum = (IDX_W+2)'(head_q) + (IDX_W+2)'(count_q);
		if (slot_sum >= (IDX_W+2)'(WINDOW_MAX)) begin
			slot_sum = slot_sum - (IDX_W+2)'(WINDOW_MAX);
		end
		slot = slot_sum[IDX_W-1:0];
	end

	// Adequacy and mean tests on the finished statistics.
	assign adq_now = full_q && (spread_q < limn_q);
	assign thr_now = adq_now && (sum_q > mint_q);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ftr_pkg::S_IDLE: begin
				if (in_xfer) begin
					if (sensor_active && subscribers_present) begin
						state_d = ftr_pkg::S_RD;
					end else begin
						state_d = ftr_pkg::S_OUT;
					end
				end
			end
			ftr_pkg::S_RD:     state_d = ftr_pkg::S_POP;
			ftr_pkg::S_POP:    state_d = ftr_pkg::S_PUSH;
			ftr_pkg::S_PUSH:   state_d = ftr_pkg::S_M1;
			ftr_pkg::S_M1:     state_d = ftr_pkg::S_M2;
			ftr_pkg::S_M2:     state_d = ftr_pkg::S_M3;
			ftr_pkg::S_M3:     state_d = ftr_pkg::S_DMEAN;
			ftr_pkg::S_DMEAN:  state_d = ftr_pkg::S_WMEAN;
			ftr_pkg::S_WMEAN:  if (div_done) state_d = ftr_pkg::S_DVAR;
			ftr_pkg::S_DVAR:   state_d = ftr_pkg::S_WVAR;
			ftr_pkg::S_WVAR:   if (div_done) state_d = ftr_pkg::S_DECIDE;
			ftr_pkg::S_DECIDE: state_d = thr_now ? ftr_pkg::S_M5 : ftr_pkg::S_OUT;
			ftr_pkg::S_M5:     state_d = ftr_pkg::S_M6;
			ftr_pkg::S_M6:     state_d = ftr_pkg::S_DRATE;
			ftr_pkg::S_DRATE:  state_d = ftr_pkg::S_WRATE;
			ftr_pkg::S_WRATE:  if (div_done) state_d = ftr_pkg::S_OUT;
			ftr_pkg::S_OUT:    if (out_ready) state_d = ftr_pkg::S_IDLE;
			default:           state_d = ftr_pkg::S_IDLE;
		endcase
	end

	// Output logic of the sequencer: handshakes, RAM and divider controls.
	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		div_start    = 1'b0;
		div_dividend = DIV_W'(sum_q);
		div_divisor  = DIV_W'(count_q);
		case (state_q)
			ftr_pkg::S_IDLE:  in_ready = 1'b1;
			ftr_pkg::S_RD:    ram_re = 1'b1;
			ftr_pkg::S_PUSH:  ram_we = 1'b1;
			ftr_pkg::S_DMEAN: div_start = 1'b1;
			ftr_pkg::S_DVAR: begin
				div_start    = 1'b1;
				div_dividend = DIV_W'(spread_q);
				div_divisor  = DIV_W'(n2_q);
			end
			ftr_pkg::S_DRATE: begin
				div_start    = 1'b1;
				div_dividend = DIV_W'(num_q);
				div_divisor  = DIV_W'(sum_q);
			end
			ftr_pkg::S_OUT:   out_valid = 1'b1;
			default: begin
			end
		endcase
	end

	// Sequencer state and window state with configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ftr_pkg::S_IDLE;
			ws_q        <= ftr_pkg::RST_WINDOW_SIZE;
			max_stdev_q <= ftr_pkg::RST_MAX_STDEV;
			max_intv_q  <= ftr_pkg::RST_MAX_INTERVAL;
			target_q    <= ftr_pkg::RST_TARGET_PER;
			head_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			last_q      <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ftr_pkg::S_IDLE: begin
					if (in_xfer) begin
						last_q <= timestamp_us;
						// A backward timestamp only matters when the event is processed.
						if (!sensor_active || (subscribers_present && backward)) begin
							head_q  <= '0;
							count_q <= '0;
							sum_q   <= '0;
							sq_q    <= '0;
						end
					end
				end
				ftr_pkg::S_POP: begin
					if (full_q) begin
						count_q <= count_q - 1'b1;
						if (head_q == IDX_W'(WINDOW_MAX - 1)) begin
							head_q <= '0;
						end else begin
							head_q <= head_q + 1'b1;
						end
					end
				end
				ftr_pkg::S_PUSH: begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q - SUM_W'(old_q) + SUM_W'(v_q);
					sq_q    <= sq_q - SQ_W'(oldsq_q) + SQ_W'(vsq_q);
				end
				ftr_pkg::S_WRATE: begin
					// A slowdown request empties the window.
					if (div_done) begin
						head_q  <= '0;
						count_q <= '0;
						sum_q   <= '0;
						sq_q    <= '0;
					end
				end
				default: begin
				end
			endcase
			if (cfg_wr_en) begin
				case (cfg_index)
					ftr_pkg::REG_WINDOW_SIZE: begin
						ws_q    <= cfg_wdata[ftr_pkg::WS_W-1:0];
						head_q  <= '0;
						count_q <= '0;
						sum_q   <= '0;
						sq_q    <= '0;
					end
					ftr_pkg::REG_MAX_STDEV:    max_stdev_q <= cfg_wdata;
					ftr_pkg::REG_MAX_INTERVAL: max_intv_q  <= cfg_wdata;
					ftr_pkg::REG_TARGET_PER:   target_q    <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// Working and result registers; at most two multiplications per step.
	always_ff @(posedge clk) begin
		case (state_q)
			ftr_pkg::S_IDLE: begin
				if (in_xfer) begin
					rate_q <= current_rate;
					v_q    <= delta;
					pub_q  <= 1'b0;
					thr_q  <= 1'b0;
					next_q <= '0;
					mean_q <= '0;
					var_q  <= '0;
					adq_q  <= 1'b0;
				end
			end
			ftr_pkg::S_RD: begin
				full_q <= count_q >= w_eff;
				vsq_q  <= SQV_W'(v_q) * SQV_W'(v_q);
			end
			ftr_pkg::S_POP: begin
				if (full_q) begin
					old_q   <= ram_rdata;
					oldsq_q <= SQV_W'(ram_rdata) * SQV_W'(ram_rdata);
				end else begin
					old_q   <= '0;
					oldsq_q <= '0;
				end
			end
			ftr_pkg::S_M1: begin
				full_q <= count_q >= w_eff;
				p1_q   <= SPR_W'(count_q) * SPR_W'(sq_q);
				n2_q   <= (2*CNT_W)'(count_q) * (2*CNT_W)'(count_q);
			end
			ftr_pkg::S_M2: begin
				p2_q   <= SPR_W'(sum_q) * SPR_W'(sum_q);
				lim2_q <= SQV_W'(max_stdev_q) * SQV_W'(max_stdev_q);
			end
			ftr_pkg::S_M3: begin
				spread_q <= p1_q - p2_q;
				limn_q   <= SPR_W'(lim2_q) * SPR_W'(n2_q);
				mint_q   <= SUM_W'(max_intv_q) * SUM_W'(count_q);
			end
			ftr_pkg::S_WMEAN: begin
				if (div_done) begin
					mean_q <= div_quo[ftr_pkg::INTV_W-1:0];
				end
			end
			ftr_pkg::S_WVAR: begin
				if (div_done) begin
					var_q <= div_quo[ftr_pkg::TS_W-1:0];
				end
			end
			ftr_pkg::S_DECIDE: begin
				pub_q <= 1'b1;
				adq_q <= adq_now;
				thr_q <= thr_now;
			end
			ftr_pkg::S_M5: begin
				num_q <= NUM_W'(RT_W'(rate_q) * RT_W'(target_q));
			end
			ftr_pkg::S_M6: begin
				num_q <= NUM_W'(num_q[RT_W-1:0]) * NUM_W'(count_q);
			end
			ftr_pkg::S_WRATE: begin
				if (div_done) begin
					if (|div_quo[DIV_W-1:ftr_pkg::RATE_W]) begin
						next_q <= '1;
					end else begin
						next_q <= div_quo[ftr_pkg::RATE_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Interval ring.
	ftr_ram #(
		.WIDTH(ftr_pkg::INTV_W),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot),
		.wdata(v_q),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// Shared divider for mean, variance and new rate.
	ftr_div #(
		.W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign published         = pub_q;
	assign throttle          = thr_q;
	assign next_rate         = next_q;
	assign mean_interval_us  = mean_q;
	assign interval_variance = var_q;
	assign adequate          = adq_q;

endmodule
